/* design/cpfr_pkg.sv */
// Package for the compressor frequency regulator.
// Holds the widths, register indexes, sequencer states and unit handshake types.
// Used by every module in the design folder.
package cpfr_pkg;

  localparam int unsigned MUL_W  = 48;
  localparam int unsigned MULB_W = 17;
  localparam int unsigned DIV_W  = 44;
  localparam int unsigned DVS_W  = 16;
  localparam int unsigned CFG_AW = 3;

  localparam logic [15:0] PERIOD_RST = 16'd500;
  localparam logic [15:0] MS_PER_S   = 16'd1000;

  typedef enum logic [CFG_AW-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_PERIOD   = 3'd3,
    CFG_FLOOR    = 3'd4,
    CFG_CEILING  = 3'd5,
    CFG_DEADBAND = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INC_MUL,
    ST_INC_DIV,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_D_SCALE,
    ST_D_DIV,
    ST_STEP_DIV,
    ST_CLAMP,
    ST_LIMIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* design/cpfr_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on cpfr_pkg for widths and the handshake structs.
module cpfr_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cpfr_pkg::unit_ctrl_t            ctrl_i,
  input  logic [cpfr_pkg::MUL_W-1:0]      a_i,
  input  logic [cpfr_pkg::MULB_W-1:0]     b_i,
  output cpfr_pkg::unit_stat_t            stat_o,
  output logic [cpfr_pkg::MUL_W-1:0]      prod_o
);

  localparam int unsigned CW = $clog2(cpfr_pkg::MULB_W + 1);

  logic [cpfr_pkg::MUL_W-1:0]  a_q, acc_q;
  logic [cpfr_pkg::MULB_W-1:0] b_q;
  logic [CW-1:0]               cnt_q;
  logic                        busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(cpfr_pkg::MULB_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[cpfr_pkg::MUL_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[cpfr_pkg::MULB_W-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

/* design/cpfr_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on cpfr_pkg for widths and the handshake structs.
module cpfr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cpfr_pkg::unit_ctrl_t            ctrl_i,
  input  logic [cpfr_pkg::DIV_W-1:0]      num_i,
  input  logic [cpfr_pkg::DVS_W-1:0]      den_i,
  output cpfr_pkg::unit_stat_t            stat_o,
  output logic [cpfr_pkg::DIV_W-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(cpfr_pkg::DIV_W + 1);

  logic [cpfr_pkg::DIV_W-1:0] num_q;
  logic [cpfr_pkg::DVS_W-1:0] den_q, rem_q;
  logic [cpfr_pkg::DVS_W:0]   shift_w, diff_w;
  logic                       fit_w;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;

  assign shift_w = {rem_q, num_q[cpfr_pkg::DIV_W-1]};
  assign diff_w  = shift_w - {1'b0, den_q};
  assign fit_w   = shift_w >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(cpfr_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit_w ? diff_w[cpfr_pkg::DVS_W-1:0] : shift_w[cpfr_pkg::DVS_W-1:0];
      num_q <= {num_q[cpfr_pkg::DIV_W-2:0], fit_w};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = num_q;

endmodule

/* design/compressor_pid_frequency_regulator_top.sv */
// Compressor frequency regulator: PID with deadband, anti-windup and slew limit.
// Depends on cpfr_pkg, cpfr_mul and cpfr_div.
//
// Usage: one beat on the slave stream carries target_temp (bits 15:0) and
// measured_temp (bits 31:16); one beat on the master stream returns
// drive_freq. The user must write the registers through cfg_we_i, cfg_addr_i
// and cfg_data_i only while the block is idle; the block does not enforce it.
// A sample that ends at the floor goes from the check straight to the output
// register. A full PID update runs, after the check, five serial multiplies and
// three serial divides, one after another on the two units, then the clamp, the
// limit and the load of the output register.
// Only one sample is in flight: a new sample is taken only once the last one
// has been loaded into the output register. s_axis_tready_o is high
// whenever the sequencer is idle, also while a result still waits in the
// output register.
// When the receiver stalls, the result beat holds and the next sample is
// worked on up to its result, which then waits for the output register.
// Reset clears the history and sets the sample period to 500 ms, all other
// registers to zero.
module compressor_pid_frequency_regulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // target_temp, measured_temp
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // drive_freq
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned MW = cpfr_pkg::MUL_W;
  localparam int unsigned DW = cpfr_pkg::DIV_W;

  cpfr_pkg::state_e state_q, state_d;

  logic [15:0] gain_p_q, gain_i_q, gain_d_q, period_q, floor_q, ceil_q;
  logic [14:0] dead_band_q;

  logic signed [16:0] err_q, prior_q;
  logic [23:0]        integ_q, prev_q, o_q;
  logic signed [MW-1:0] sum_q;
  logic               dsgn_q;
  logic [16:0]        step_q;
  logic [15:0]        res_q;
  logic               issued_q;
  logic               out_valid_q;
  logic [15:0]        out_data_q;

  cpfr_pkg::unit_ctrl_t mul_ctrl, div_ctrl;
  cpfr_pkg::unit_stat_t mul_st, div_st;
  logic [MW-1:0]              mul_a, mul_p;
  logic [cpfr_pkg::MULB_W-1:0] mul_b;
  logic [DW-1:0]              div_n, div_q;
  logic [15:0]                div_d;

  logic        in_acc, slot_free;
  logic [23:0] span;
  logic signed [17:0] err_x, db_x, diff_x;
  logic [16:0] dmag;
  logic        empty_rng, err_le0, err_le_ndb, err_lt_db;
  logic [24:0] acc_sum;
  logic [23:0] acc_clamp;
  logic [39:0] sum_sh;
  logic signed [26:0] o_x, p_x, s_x, hi_x, lo_x, sel_x, span_x;
  logic [23:0] lim;
  logic [MW-1:0] dq_ext;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == cpfr_pkg::ST_IDLE);

  assign span       = {ceil_q - floor_q, 8'd0};
  assign err_x      = {err_q[16], err_q};
  assign db_x       = {3'd0, dead_band_q};
  assign empty_rng  = ceil_q <= floor_q;
  assign err_le0    = err_x <= 18'sd0;
  assign err_le_ndb = err_x <= -db_x;
  assign err_lt_db  = err_x < db_x;
  assign diff_x     = err_x - {prior_q[16], prior_q};
  assign dmag       = diff_x[17] ? 17'(-diff_x) : diff_x[16:0];

  assign acc_sum   = {1'b0, integ_q} + div_q[24:0];
  assign acc_clamp = (acc_sum > {1'b0, span}) ? span : acc_sum[23:0];
  assign dq_ext    = {{(MW-DW){1'b0}}, div_q};
  assign sum_sh    = sum_q[47:8];

  assign o_x    = {3'd0, o_q};
  assign p_x    = {3'd0, prev_q};
  assign s_x    = {10'd0, step_q};
  assign span_x = {3'd0, span};
  assign hi_x   = p_x + s_x;
  assign lo_x   = p_x - s_x;

  always_comb begin
    if (o_x > hi_x) begin
      sel_x = hi_x;
    end else if (o_x < lo_x) begin
      sel_x = lo_x;
    end else begin
      sel_x = o_x;
    end
    if (sel_x < 27'sd0) begin
      lim = '0;
    end else if (sel_x > span_x) begin
      lim = span;
    end else begin
      lim = sel_x[23:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cpfr_pkg::ST_IDLE: begin
        if (in_acc) state_d = cpfr_pkg::ST_CHECK;
      end
      cpfr_pkg::ST_CHECK: begin
        if (empty_rng || err_le0 || err_lt_db) begin
          state_d = cpfr_pkg::ST_OUT;
        end else begin
          state_d = cpfr_pkg::ST_INC_MUL;
        end
      end
      cpfr_pkg::ST_INC_MUL:  if (mul_st.done) state_d = cpfr_pkg::ST_INC_DIV;
      cpfr_pkg::ST_INC_DIV:  if (div_st.done) state_d = cpfr_pkg::ST_P_MUL;
      cpfr_pkg::ST_P_MUL:    if (mul_st.done) state_d = cpfr_pkg::ST_I_MUL;
      cpfr_pkg::ST_I_MUL:    if (mul_st.done) state_d = cpfr_pkg::ST_D_MUL;
      cpfr_pkg::ST_D_MUL:    if (mul_st.done) state_d = cpfr_pkg::ST_D_SCALE;
      cpfr_pkg::ST_D_SCALE:  if (mul_st.done) state_d = cpfr_pkg::ST_D_DIV;
      cpfr_pkg::ST_D_DIV:    if (div_st.done) state_d = cpfr_pkg::ST_STEP_DIV;
      cpfr_pkg::ST_STEP_DIV: if (div_st.done) state_d = cpfr_pkg::ST_CLAMP;
      cpfr_pkg::ST_CLAMP:    state_d = cpfr_pkg::ST_LIMIT;
      cpfr_pkg::ST_LIMIT:    state_d = cpfr_pkg::ST_OUT;
      cpfr_pkg::ST_OUT: begin
        if (slot_free) state_d = cpfr_pkg::ST_IDLE;
      end
      default: state_d = cpfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_ctrl.start = 1'b0;
    div_ctrl.start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = cpfr_pkg::MS_PER_S;
    case (state_q)
      cpfr_pkg::ST_INC_MUL: begin
        mul_ctrl.start = !issued_q;
        mul_a = {{(MW-16){1'b0}}, err_q[15:0]};
        mul_b = {1'b0, period_q};
      end
      cpfr_pkg::ST_INC_DIV: begin
        div_ctrl.start = !issued_q;
        div_n = mul_p[DW-1:0];
      end
      cpfr_pkg::ST_P_MUL: begin
        mul_ctrl.start = !issued_q;
        mul_a = {{(MW-16){1'b0}}, err_q[15:0]};
        mul_b = {1'b0, gain_p_q};
      end
      cpfr_pkg::ST_I_MUL: begin
        mul_ctrl.start = !issued_q;
        mul_a = {{(MW-24){1'b0}}, integ_q};
        mul_b = {1'b0, gain_i_q};
      end
      cpfr_pkg::ST_D_MUL: begin
        mul_ctrl.start = !issued_q;
        mul_a = {{(MW-17){1'b0}}, dmag};
        mul_b = {1'b0, gain_d_q};
      end
      cpfr_pkg::ST_D_SCALE: begin
        mul_ctrl.start = !issued_q;
        mul_a = mul_p;
        mul_b = {1'b0, cpfr_pkg::MS_PER_S};
      end
      cpfr_pkg::ST_D_DIV: begin
        div_ctrl.start = !issued_q;
        div_n = mul_p[DW-1:0];
        div_d = (period_q == 16'd0) ? 16'd1 : period_q;
      end
      cpfr_pkg::ST_STEP_DIV: begin
        div_ctrl.start = !issued_q;
        div_n = {{(DW-26){1'b0}}, period_q, 10'd0};
      end
      default: begin
        mul_ctrl.start = 1'b0;
      end
    endcase
  end

  cpfr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_st),
    .prod_o (mul_p)
  );

  cpfr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (div_n),
    .den_i  (div_d),
    .stat_o (div_st),
    .quot_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpfr_pkg::ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      period_q    <= cpfr_pkg::PERIOD_RST;
      floor_q     <= '0;
      ceil_q      <= '0;
      dead_band_q <= '0;
      prior_q     <= '0;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      state_q <= state_d;
      if (mul_ctrl.start || div_ctrl.start) begin
        issued_q <= 1'b1;
      end else if (mul_st.done || div_st.done) begin
        issued_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          cpfr_pkg::CFG_GAIN_P:   gain_p_q    <= cfg_data_i;
          cpfr_pkg::CFG_GAIN_I:   gain_i_q    <= cfg_data_i;
          cpfr_pkg::CFG_GAIN_D:   gain_d_q    <= cfg_data_i;
          cpfr_pkg::CFG_PERIOD:   period_q    <= cfg_data_i;
          cpfr_pkg::CFG_FLOOR:    floor_q     <= cfg_data_i;
          cpfr_pkg::CFG_CEILING:  ceil_q      <= cfg_data_i;
          cpfr_pkg::CFG_DEADBAND: dead_band_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (state_q == cpfr_pkg::ST_CHECK && !empty_rng) begin
        if (err_le0) begin
          prev_q <= '0;
          if (err_le_ndb) begin
            prior_q <= '0;
            integ_q <= '0;
          end
        end else if (err_lt_db) begin
          prior_q <= '0;
          prev_q  <= '0;
        end
      end
      if (state_q == cpfr_pkg::ST_INC_DIV && div_st.done) begin
        integ_q <= acc_clamp;
      end
      if (state_q == cpfr_pkg::ST_LIMIT) begin
        prior_q <= err_q;
        prev_q  <= lim;
      end
      if (state_q == cpfr_pkg::ST_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q <= 17'($signed(s_axis_tdata_i[31:16])) - 17'($signed(s_axis_tdata_i[15:0]));
    end
    if (state_q == cpfr_pkg::ST_CHECK) begin
      res_q  <= floor_q;
      dsgn_q <= diff_x[17];
    end
    if (state_q == cpfr_pkg::ST_P_MUL && mul_st.done) begin
      sum_q <= $signed(mul_p);
    end
    if (state_q == cpfr_pkg::ST_I_MUL && mul_st.done) begin
      sum_q <= sum_q + $signed(mul_p);
    end
    if (state_q == cpfr_pkg::ST_D_DIV && div_st.done) begin
      sum_q <= dsgn_q ? (sum_q - $signed(dq_ext)) : (sum_q + $signed(dq_ext));
    end
    if (state_q == cpfr_pkg::ST_STEP_DIV && div_st.done) begin
      step_q <= div_q[16:0];
    end
    if (state_q == cpfr_pkg::ST_CLAMP) begin
      if (sum_q[MW-1]) begin
        o_q <= '0;
      end else if (sum_sh > {16'd0, span}) begin
        o_q <= span;
      end else begin
        o_q <= sum_sh[23:0];
      end
    end
    if (state_q == cpfr_pkg::ST_LIMIT) begin
      res_q <= floor_q + lim[23:8];
    end
    if (state_q == cpfr_pkg::ST_OUT && slot_free) begin
      out_data_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_st.busy && div_st.busy))
    else $error("multiplier and divider busy together");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpfr_pkg::ST_OUT && slot_free) |=> m_axis_tvalid_o)
    else $error("result beat not presented");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == cpfr_pkg::ST_CHECK && !mul_st.busy && !div_st.busy))
    else $error("sample accepted while a unit was busy");

endmodule
